// File: hw/rtl/oht_pkg.sv
// ----------------------------------------------------------------------------
// oht_pkg
// Request codes, status codes, field widths and shared types for the ordered
// open-address hash table.
// ----------------------------------------------------------------------------
package oht_pkg;

  localparam int HASH_W  = 32;
  localparam int TAG_W   = 64;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 9;
  localparam int SLOT_W  = 8;

  localparam logic [1:0] REQ_LOOKUP   = 2'd0;
  localparam logic [1:0] REQ_SET      = 2'd1;
  localparam logic [1:0] REQ_READ_POS = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic rd;
    logic append;
  } ord_cmd_t;

endpackage

// File: hw/rtl/oht_index.sv
// ----------------------------------------------------------------------------
// oht_index
// Reduces a 32-bit probe counter to a slot number modulo the table capacity.
// ----------------------------------------------------------------------------
module oht_index #(
  parameter int CAPACITY = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [oht_pkg::HASH_W-1:0]            probe_val,
  output logic                                  done,
  output logic [$clog2(CAPACITY)-1:0]           slot
);

  localparam int SW = $clog2(CAPACITY);

  generate
    if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_mask
      logic          done_q;
      logic [SW-1:0] slot_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start;
        end
        if (start) begin
          slot_q <= probe_val[SW-1:0];
        end
      end

      assign done = done_q;
      assign slot = slot_q;
    end else begin : g_reduce
      localparam logic [SW:0] CAP_V = (SW + 1)'(CAPACITY);

      logic                        busy;
      logic                        done_q;
      logic [1:0]                  cnt;
      logic [oht_pkg::HASH_W-1:0]  word;
      logic [SW-1:0]               rem;
      logic [SW-1:0]               rem_next;

      // Eight bits of the counter are folded into the remainder per cycle.
      always_comb begin
        logic [SW:0] t;
        rem_next = rem;
        for (int k = 0; k < 8; k++) begin
          t = {rem_next, word[oht_pkg::HASH_W-1-k]};
          if (t >= CAP_V) begin
            t = t - CAP_V;
          end
          rem_next = t[SW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy   <= 1'b0;
          done_q <= 1'b0;
          cnt    <= 2'd0;
        end else begin
          done_q <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= 2'd0;
          end else if (busy) begin
            cnt <= cnt + 2'd1;
            if (cnt == 2'd3) begin
              busy   <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
        if (start) begin
          word <= probe_val;
          rem  <= '0;
        end else if (busy) begin
          word <= {word[oht_pkg::HASH_W-9:0], 8'h00};
          rem  <= rem_next;
        end
      end

      assign done = done_q;
      assign slot = rem;
    end
  endgenerate

endmodule

// File: hw/rtl/oht_order.sv
// ----------------------------------------------------------------------------
// oht_order
// Insertion-order list: entry count, slot list memory and position resolve.
// ----------------------------------------------------------------------------
module oht_order #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  oht_pkg::ord_cmd_t                    cmd,
  input  logic [$clog2(CAPACITY)-1:0]          app_slot,
  input  logic signed [oht_pkg::POS_W-1:0]     pos,
  output logic                                 in_range,
  output logic [$clog2(CAPACITY)-1:0]          rd_slot,
  output logic [$clog2(CAPACITY + 1)-1:0]      count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > oht_pkg::POS_W) ? CW : oht_pkg::POS_W) + 1;

  logic [SW-1:0]        order_mem [CAPACITY];
  logic signed [PW-1:0] p_ext;
  logic signed [PW-1:0] cnt_s;
  logic signed [PW-1:0] p_adj;

  always_comb begin
    p_ext    = PW'(pos);
    cnt_s    = PW'({1'b0, count});
    p_adj    = p_ext[PW-1] ? (p_ext + cnt_s) : p_ext;
    in_range = !p_adj[PW-1] && (p_adj < cnt_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end
    if (cmd.append) begin
      order_mem[count[SW-1:0]] <= app_slot;
    end
    if (cmd.rd) begin
      rd_slot <= order_mem[p_adj[SW-1:0]];
    end
  end

endmodule

// File: hw/rtl/ordered_open_address_hash_table.sv
// ----------------------------------------------------------------------------
// ordered_open_address_hash_table
// Key-value table with perturbed open-address probing and an insertion-order
// list that can be read by position.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         request beat: tuser req_type, tdata hash/tag/value/pos
//  m_*      out        result beat: tuser status, tdata found/value/slot
//
//  Lookup and set: each probe takes a slot index (masked with a power-of-two
//  capacity, modulo reducer otherwise), then the slot memory read.
//  Read by position does a list memory read, then a slot memory read.
//  After reset every slot of the slot memory is cleared, with s_tready low.
//  A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module ordered_open_address_hash_table #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_hash[31:0], key_tag[95:32], value_in[127:96], position[136:128]
  input  logic [143:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], value_out[32:1], slot_index[40:33]
  output logic [47:0]  m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);

  localparam int SW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int VW          = (VALUE_WIDTH < oht_pkg::DATA_W) ? VALUE_WIDTH : oht_pkg::DATA_W;
  localparam int PROBE_LIMIT = CAPACITY + 8;
  localparam int NW          = $clog2(CAPACITY + 9);
  localparam int LOAD_MAX    = CAPACITY * 3 / 4;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_IDX   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_POS   = 3'd4;
  localparam logic [2:0] S_POSR  = 3'd5;
  localparam logic [2:0] S_POSV  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  typedef struct packed {
    logic                        used;
    logic [oht_pkg::HASH_W-1:0]  hash;
    logic [oht_pkg::TAG_W-1:0]   tag;
    logic [VW-1:0]               value;
  } slot_word_t;

  logic [2:0]                        state;
  logic [1:0]                        req;
  logic [oht_pkg::HASH_W-1:0]        hash;
  logic [oht_pkg::TAG_W-1:0]         tag;
  logic [VW-1:0]                     val;
  logic signed [oht_pkg::POS_W-1:0]  pos;
  logic [oht_pkg::HASH_W-1:0]        pi;
  logic [oht_pkg::HASH_W-1:0]        perturb;
  logic [oht_pkg::HASH_W-1:0]        pi_next;
  logic [NW-1:0]                     nprobe;
  logic [SW-1:0]                     cur_slot;
  logic [SW-1:0]                     clr_cnt;

  logic                              res_found;
  logic [oht_pkg::DATA_W-1:0]        res_val;
  logic [1:0]                        res_status;
  logic [oht_pkg::SLOT_W-1:0]        res_slot;

  logic                              out_found;
  logic [oht_pkg::DATA_W-1:0]        out_val;
  logic [1:0]                        out_status;
  logic [oht_pkg::SLOT_W-1:0]        out_slot;

  slot_word_t                        slot_mem [CAPACITY];
  slot_word_t                        slot_rd;
  slot_word_t                        wr_word;
  logic                              mem_we;
  logic [SW-1:0]                     wr_addr;
  logic                              mem_re;
  logic [SW-1:0]                     rd_addr;

  logic                              accept;
  logic                              idx_start;
  logic [oht_pkg::HASH_W-1:0]        idx_val;
  logic                              idx_done;
  logic [SW-1:0]                     idx_slot;

  oht_pkg::ord_cmd_t                 ord_cmd;
  logic                              ord_in_range;
  logic [SW-1:0]                     ord_slot;
  logic [CW-1:0]                     count;

  logic                              hit;
  logic                              empty;
  logic                              last;
  logic                              finish;
  logic                              full;
  logic                              is_set;
  logic                              ins;
  logic                              upd;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, out_slot, out_val, out_found};
  assign m_tuser  = out_status;

  always_comb begin
    pi_next = (pi << 2) + pi + oht_pkg::HASH_W'(1) + perturb;
    hit     = slot_rd.used && (slot_rd.hash == hash) && (slot_rd.tag == tag);
    empty   = !slot_rd.used;
    last    = (nprobe == NW'(PROBE_LIMIT - 1));
    finish  = hit || empty || last;
    full    = (count > CW'(LOAD_MAX)) || (count >= CW'(CAPACITY));
    is_set  = (req == oht_pkg::REQ_SET);
    ins     = is_set && !hit && empty && !full;
    upd     = is_set && hit;

    idx_start = (accept && (s_tuser != oht_pkg::REQ_READ_POS)) ||
                ((state == S_CMP) && !finish);
    idx_val   = (state == S_IDLE) ? s_tdata[31:0] : pi_next;

    mem_we  = (state == S_CLEAR) || ((state == S_CMP) && (ins || upd));
    wr_addr = (state == S_CLEAR) ? clr_cnt : cur_slot;
    wr_word = '0;
    if (state != S_CLEAR) begin
      wr_word.used  = 1'b1;
      wr_word.hash  = hash;
      wr_word.tag   = tag;
      wr_word.value = val;
    end

    mem_re  = ((state == S_IDX) && idx_done) || (state == S_POSR);
    rd_addr = (state == S_POSR) ? ord_slot : idx_slot;

    ord_cmd.append = (state == S_CMP) && ins;
    ord_cmd.rd     = (state == S_POS) && ord_in_range;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_word;
    end
    if (mem_re) begin
      slot_rd <= slot_mem[rd_addr];
    end
  end

  oht_index #(
    .CAPACITY (CAPACITY)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .start     (idx_start),
    .probe_val (idx_val),
    .done      (idx_done),
    .slot      (idx_slot)
  );

  oht_order #(
    .CAPACITY (CAPACITY)
  ) u_order (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ord_cmd),
    .app_slot (cur_slot),
    .pos      (pos),
    .in_range (ord_in_range),
    .rd_slot  (ord_slot),
    .count    (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_cnt == SW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= (s_tuser == oht_pkg::REQ_READ_POS) ? S_POS : S_IDX;
          end
        end
        S_IDX: begin
          if (idx_done) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= finish ? S_RESP : S_IDX;
        end
        S_POS: begin
          state <= ord_in_range ? S_POSR : S_RESP;
        end
        S_POSR: begin
          state <= S_POSV;
        end
        S_POSV: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= s_tuser;
      hash    <= s_tdata[31:0];
      tag     <= s_tdata[95:32];
      val     <= s_tdata[96 +: VW];
      pos     <= s_tdata[136:128];
      pi      <= s_tdata[31:0];
      perturb <= s_tdata[31:0];
      nprobe  <= '0;
    end else if ((state == S_CMP) && !finish) begin
      pi      <= pi_next;
      perturb <= perturb >> 5;
      nprobe  <= nprobe + NW'(1);
    end

    if ((state == S_IDX) && idx_done) begin
      cur_slot <= idx_slot;
    end else if (state == S_POSR) begin
      cur_slot <= ord_slot;
    end

    if ((state == S_CMP) && finish) begin
      if (hit) begin
        res_found  <= 1'b1;
        res_val    <= oht_pkg::DATA_W'(slot_rd.value);
        res_status <= oht_pkg::ST_OK;
        res_slot   <= oht_pkg::SLOT_W'(cur_slot);
      end else if (ins) begin
        res_found  <= 1'b0;
        res_val    <= '0;
        res_status <= oht_pkg::ST_OK;
        res_slot   <= oht_pkg::SLOT_W'(cur_slot);
      end else begin
        res_found  <= 1'b0;
        res_val    <= '0;
        res_status <= is_set ? oht_pkg::ST_FULL : oht_pkg::ST_ABSENT;
        res_slot   <= '0;
      end
    end else if ((state == S_POS) && !ord_in_range) begin
      res_found  <= 1'b0;
      res_val    <= '0;
      res_status <= oht_pkg::ST_RANGE;
      res_slot   <= '0;
    end else if (state == S_POSV) begin
      res_found  <= 1'b1;
      res_val    <= oht_pkg::DATA_W'(slot_rd.value);
      res_status <= oht_pkg::ST_OK;
      res_slot   <= oht_pkg::SLOT_W'(cur_slot);
    end

    if ((state == S_RESP) && (!m_tvalid || m_tready)) begin
      out_found  <= res_found;
      out_val    <= res_val;
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

endmodule
